### rtl/core/bhx_pkg.sv
`timescale 1ns / 1ps

package bhx_pkg;

    localparam logic [7:0]  RUN_MARK = 8'h90;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // Result kinds as they appear on the output tuser.
    localparam logic [1:0] KIND_DATA    = 2'd0;
    localparam logic [1:0] KIND_END     = 2'd1;
    localparam logic [1:0] KIND_ILLEGAL = 2'd2;

    typedef enum logic [1:0] {
        SYM_DATA,
        SYM_SKIP,
        SYM_DONE,
        SYM_FAIL
    } sym_class_t;

    typedef struct packed {
        sym_class_t  cls;
        logic [5:0]  sym;
    } sym_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_FIN0,
        ST_FIN1,
        ST_EMIT
    } state_t;

endpackage

### rtl/core/six_bit_rle_crc_decoder.sv
`timescale 1ns / 1ps

// Six-bit text decoder with run-length expansion and a CRC-16 check value.
// Input channel: one text character per transfer on s_tdata, with s_tuser
// high to clear the checksum instead. Output channel: at most one result
// per input transfer; m_tuser gives the kind (data run, end marker, illegal
// character) and m_tdata the byte, its repeat count and the finalized CRC.
// Characters that give no result (line breaks, the first symbol of a group,
// a run marker, a count of one, a clear) leave the sequencer idle. For a
// character that gives a result, one shared byte-wide CRC unit is stepped
// once per byte in the run (none for end and illegal results), then twice
// more with zero bytes to finalize, and then the output register is loaded.
// The longest run has 254 copies.
// s_tready is high only while the sequencer is idle; a finished result sits
// in the output register, and the next character is taken meanwhile. When
// the receiver stalls, a further result waits until the register frees.
// Reset clears the symbol alignment, saved bits, CRC and last byte.

module six_bit_rle_crc_decoder
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // char_code[7:0]
    input  logic        s_tuser,    // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // data_byte[7:0], repeat_res[15:8], check_value[31:16]
    output logic [1:0]  m_tuser     // kind
);

    bhx_pkg::state_t state_reg, state_next;
    logic [2:0]  phase_reg, phase_next;
    logic [5:0]  saved_reg, saved_next;
    logic [15:0] crc_reg, crc_next;
    logic [15:0] fin_reg, fin_next;
    logic [7:0]  last_reg, last_next;
    logic [7:0]  run_byte_reg, run_byte_next;
    logic [7:0]  cnt_reg, cnt_next;
    logic [1:0]  res_kind_reg, res_kind_next;
    logic [7:0]  res_rep_reg, res_rep_next;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [31:0] m_tdata_reg, m_tdata_next;
    logic [1:0]  m_tuser_reg, m_tuser_next;

    bhx_pkg::sym_t msym;
    logic [15:0] unit_crc;
    logic [7:0]  unit_byte;
    logic [15:0] unit_out;

    bhx_map u_map
    (
        .char_code (s_tdata),
        .sym       (msym)
    );

    // The single CRC unit serves the run bytes and both finalizing steps.
    assign unit_crc  = (state_reg == bhx_pkg::ST_FIN1) ? fin_reg : crc_reg;
    assign unit_byte = (state_reg == bhx_pkg::ST_RUN) ? run_byte_reg : 8'h00;

    bhx_crc u_crc
    (
        .crc_in  (unit_crc),
        .byte_in (unit_byte),
        .crc_out (unit_out)
    );

    assign s_tready = (state_reg == bhx_pkg::ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= bhx_pkg::ST_IDLE;
            phase_reg    <= 3'd0;
            saved_reg    <= 6'd0;
            crc_reg      <= 16'd0;
            last_reg     <= 8'd0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            saved_reg    <= saved_next;
            crc_reg      <= crc_next;
            last_reg     <= last_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fin_reg      <= fin_next;
        run_byte_reg <= run_byte_next;
        cnt_reg      <= cnt_next;
        res_kind_reg <= res_kind_next;
        res_rep_reg  <= res_rep_next;
        m_tdata_reg  <= m_tdata_next;
        m_tuser_reg  <= m_tuser_next;
    end

    always_comb
    begin
        logic [1:0] slot;
        logic [1:0] nslot;
        logic [7:0] b;
        logic       emit;
        logic [7:0] emit_byte;
        logic [7:0] emit_rep;

        state_next    = state_reg;
        phase_next    = phase_reg;
        saved_next    = saved_reg;
        crc_next      = crc_reg;
        fin_next      = fin_reg;
        last_next     = last_reg;
        run_byte_next = run_byte_reg;
        cnt_next      = cnt_reg;
        res_kind_next = res_kind_reg;
        res_rep_next  = res_rep_reg;
        m_tvalid_next = m_tvalid_reg & ~m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;

        slot      = phase_reg[1:0];
        nslot     = slot + 2'd1;
        b         = 8'h00;
        emit      = 1'b0;
        emit_byte = 8'h00;
        emit_rep  = 8'h00;

        unique case (state_reg)
            bhx_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tuser)
                    begin
                        crc_next = 16'd0;
                    end
                    else
                    begin
                        case (msym.cls)
                            bhx_pkg::SYM_DONE:
                            begin
                                res_kind_next = bhx_pkg::KIND_END;
                                res_rep_next  = 8'd0;
                                run_byte_next = 8'd0;
                                state_next    = bhx_pkg::ST_FIN0;
                            end
                            bhx_pkg::SYM_FAIL:
                            begin
                                res_kind_next = bhx_pkg::KIND_ILLEGAL;
                                res_rep_next  = 8'd0;
                                run_byte_next = 8'd0;
                                state_next    = bhx_pkg::ST_FIN0;
                            end
                            bhx_pkg::SYM_DATA:
                            begin
                                case (slot)
                                    2'd1:
                                    begin
                                        b          = {saved_reg, msym.sym[5:4]};
                                        saved_next = {2'b00, msym.sym[3:0]};
                                    end
                                    2'd2:
                                    begin
                                        b          = {saved_reg[3:0], msym.sym[5:2]};
                                        saved_next = {4'b0000, msym.sym[1:0]};
                                    end
                                    2'd3:
                                    begin
                                        b = {saved_reg[1:0], msym.sym};
                                    end
                                    default:
                                    begin
                                        saved_next = msym.sym;
                                        phase_next = {phase_reg[2], 2'd1};
                                    end
                                endcase
                                if (slot != 2'd0)
                                begin
                                    if (!phase_reg[2])
                                    begin
                                        if (b == bhx_pkg::RUN_MARK)
                                        begin
                                            phase_next = {1'b1, nslot};
                                        end
                                        else
                                        begin
                                            phase_next = {1'b0, nslot};
                                            emit       = 1'b1;
                                            emit_byte  = b;
                                            emit_rep   = 8'd1;
                                        end
                                    end
                                    else
                                    begin
                                        phase_next = {1'b0, nslot};
                                        if (b == 8'd0)
                                        begin
                                            emit      = 1'b1;
                                            emit_byte = bhx_pkg::RUN_MARK;
                                            emit_rep  = 8'd1;
                                        end
                                        else if (b != 8'd1)
                                        begin
                                            // A count of one adds no copies.
                                            emit      = 1'b1;
                                            emit_byte = last_reg;
                                            emit_rep  = b - 8'd1;
                                        end
                                    end
                                end
                                if (emit)
                                begin
                                    last_next     = emit_byte;
                                    run_byte_next = emit_byte;
                                    cnt_next      = emit_rep;
                                    res_kind_next = bhx_pkg::KIND_DATA;
                                    res_rep_next  = emit_rep;
                                    state_next    = bhx_pkg::ST_RUN;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
            end
            bhx_pkg::ST_RUN:
            begin
                crc_next = unit_out;
                cnt_next = cnt_reg - 8'd1;
                if (cnt_reg == 8'd1)
                begin
                    state_next = bhx_pkg::ST_FIN0;
                end
            end
            bhx_pkg::ST_FIN0:
            begin
                fin_next   = unit_out;
                state_next = bhx_pkg::ST_FIN1;
            end
            bhx_pkg::ST_FIN1:
            begin
                fin_next   = unit_out;
                state_next = bhx_pkg::ST_EMIT;
            end
            bhx_pkg::ST_EMIT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = res_kind_reg;
                    m_tdata_next  = {fin_reg, res_rep_reg, run_byte_reg};
                    state_next    = bhx_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bhx_pkg::ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_data_rep_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == bhx_pkg::KIND_DATA) |-> (m_tdata[15:8] != 8'd0))
        else $error("data result with zero repeat count");

    a_flag_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != bhx_pkg::KIND_DATA) |-> (m_tdata[15:0] == 16'd0))
        else $error("end or illegal result carries byte data");

    a_run_count_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bhx_pkg::ST_RUN) |-> (cnt_reg != 8'd0))
        else $error("run stepping with an empty count");

    a_fin_to_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bhx_pkg::ST_FIN1) |=> (state_reg == bhx_pkg::ST_EMIT))
        else $error("finalize did not lead to result load");
`endif

endmodule

### rtl/core/bhx_map.sv
`timescale 1ns / 1ps

module bhx_map
(
    input  logic [7:0]    char_code,
    output bhx_pkg::sym_t sym
);

    always_comb
    begin
        sym.cls = bhx_pkg::SYM_DATA;
        sym.sym = 6'd0;
        unique case (char_code) inside
            8'h0A, 8'h0D:    sym.cls = bhx_pkg::SYM_SKIP;
            8'h3A:           sym.cls = bhx_pkg::SYM_DONE;
            [8'h21:8'h2D]:   sym.sym = 6'(char_code - 8'h21);
            [8'h30:8'h36]:   sym.sym = 6'(char_code - 8'h30 + 8'd13);
            [8'h38:8'h39]:   sym.sym = 6'(char_code - 8'h38 + 8'd20);
            [8'h40:8'h4E]:   sym.sym = 6'(char_code - 8'h40 + 8'd22);
            [8'h50:8'h56]:   sym.sym = 6'(char_code - 8'h50 + 8'd37);
            [8'h58:8'h5B]:   sym.sym = 6'(char_code - 8'h58 + 8'd44);
            [8'h60:8'h66]:   sym.sym = 6'(char_code - 8'h60 + 8'd48);
            [8'h68:8'h6D]:   sym.sym = 6'(char_code - 8'h68 + 8'd55);
            [8'h70:8'h72]:   sym.sym = 6'(char_code - 8'h70 + 8'd61);
            default:         sym.cls = bhx_pkg::SYM_FAIL;
        endcase
    end

endmodule

### rtl/core/bhx_crc.sv
`timescale 1ns / 1ps

module bhx_crc
(
    input  logic [15:0] crc_in,
    input  logic [7:0]  byte_in,
    output logic [15:0] crc_out
);

    // Augmented form: message bits enter at the low end, MSB first.
    always_comb
    begin
        logic [15:0] r;
        logic        top;
        r = crc_in;
        for (int i = 7; i >= 0; i--)
        begin
            top = r[15];
            r = {r[14:0], byte_in[i]};
            if (top)
            begin
                r = r ^ bhx_pkg::CRC_POLY;
            end
        end
        crc_out = r;
    end

endmodule

### tb/sv/bhx_result_checker.sv
`timescale 1ns / 1ps

module bhx_result_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic [1:0]  m_tuser,
    output int          mismatches,
    output int          outstanding,
    output int          data_runs,
    output int          long_runs,
    output int          end_marks,
    output int          bad_chars,
    output logic [1:0]  symbol_slot
);

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  value;
        logic [7:0]  copies;
        logic [15:0] check;
    } decoded_t;

    decoded_t pending_results[$];

    // Decoder state as the block should hold it.
    logic [2:0]  dec_phase  = '0;
    logic [5:0]  carry_bits = '0;
    logic [15:0] crc_acc    = '0;
    logic [7:0]  prev_value = '0;

    // Position of the next legal symbol within its group of four.
    assign symbol_slot = dec_phase[1:0];

    function automatic bhx_pkg::sym_t classify_char(input logic [7:0] c);
        bhx_pkg::sym_t s;
        s.cls = bhx_pkg::SYM_DATA;
        s.sym = '0;
        if (c == 8'h0A || c == 8'h0D)      s.cls = bhx_pkg::SYM_SKIP;
        else if (c == 8'h3A)               s.cls = bhx_pkg::SYM_DONE;
        else if (c >= 8'h21 && c <= 8'h2D) s.sym = 6'(c - 8'h21);
        else if (c >= 8'h30 && c <= 8'h36) s.sym = 6'(c - 8'h30 + 13);
        else if (c >= 8'h38 && c <= 8'h39) s.sym = 6'(c - 8'h38 + 20);
        else if (c >= 8'h40 && c <= 8'h4E) s.sym = 6'(c - 8'h40 + 22);
        else if (c >= 8'h50 && c <= 8'h56) s.sym = 6'(c - 8'h50 + 37);
        else if (c >= 8'h58 && c <= 8'h5B) s.sym = 6'(c - 8'h58 + 44);
        else if (c >= 8'h60 && c <= 8'h66) s.sym = 6'(c - 8'h60 + 48);
        else if (c >= 8'h68 && c <= 8'h6D) s.sym = 6'(c - 8'h68 + 55);
        else if (c >= 8'h70 && c <= 8'h72) s.sym = 6'(c - 8'h70 + 61);
        else                               s.cls = bhx_pkg::SYM_FAIL;
        return s;
    endfunction

    // Augmented CRC: the message bits enter at the low end of the register.
    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] value);
        logic [16:0] r;
        r = {1'b0, crc};
        for (int i = 7; i >= 0; i--)
        begin
            r = {r[15:0], value[i]};
            if (r[16])
                r[15:0] = r[15:0] ^ bhx_pkg::CRC_POLY;
        end
        return r[15:0];
    endfunction

    function automatic logic [15:0] crc_finish(input logic [15:0] crc);
        return crc_step(crc_step(crc, 8'h00), 8'h00);
    endfunction

    task automatic queue_result(input logic [1:0] kind, input logic [7:0] value,
                                input logic [7:0] copies);
        decoded_t r;
        r.kind   = kind;
        r.value  = value;
        r.copies = copies;
        r.check  = crc_finish(crc_acc);
        pending_results.push_back(r);
    endtask

    task automatic emit_run(input logic [7:0] value, input logic [7:0] copies);
        if (copies == 0)
            return;
        repeat (copies) crc_acc = crc_step(crc_acc, value);
        prev_value = value;
        queue_result(bhx_pkg::KIND_DATA, value, copies);
    endtask

    task automatic take_data(input logic [7:0] value, input logic [2:0] next_phase,
                             input logic [2:0] count_phase);
        if (value == bhx_pkg::RUN_MARK)
        begin
            dec_phase = count_phase;
            return;
        end
        dec_phase = next_phase;
        emit_run(value, 8'd1);
    endtask

    // A count of zero stands for a literal marker byte.
    task automatic take_count(input logic [7:0] n, input logic [2:0] next_phase);
        dec_phase = next_phase;
        if (n == 0)
            emit_run(bhx_pkg::RUN_MARK, 8'd1);
        else
            emit_run(prev_value, n - 8'd1);
    endtask

    task automatic advance_decoder(input logic clr, input logic [7:0] code);
        bhx_pkg::sym_t s;
        logic [5:0]    sv;
        if (clr)
        begin
            crc_acc = '0;
            return;
        end
        s  = classify_char(code);
        sv = carry_bits;
        case (s.cls)
            bhx_pkg::SYM_SKIP: ;
            bhx_pkg::SYM_DONE: queue_result(bhx_pkg::KIND_END, 8'h00, 8'h00);
            bhx_pkg::SYM_FAIL: queue_result(bhx_pkg::KIND_ILLEGAL, 8'h00, 8'h00);
            default:
            begin
                case (dec_phase)
                    3'd0:
                    begin
                        carry_bits = s.sym;
                        dec_phase  = 3'd1;
                    end
                    3'd1:
                    begin
                        carry_bits = {2'b00, s.sym[3:0]};
                        take_data({sv, s.sym[5:4]}, 3'd2, 3'd6);
                    end
                    3'd2:
                    begin
                        carry_bits = {4'b0000, s.sym[1:0]};
                        take_data({sv[3:0], s.sym[5:2]}, 3'd3, 3'd7);
                    end
                    3'd3:
                        take_data({sv[1:0], s.sym}, 3'd0, 3'd4);
                    3'd4:
                    begin
                        carry_bits = s.sym;
                        dec_phase  = 3'd5;
                    end
                    3'd5:
                    begin
                        carry_bits = {2'b00, s.sym[3:0]};
                        take_count({sv, s.sym[5:4]}, 3'd2);
                    end
                    3'd6:
                    begin
                        carry_bits = {4'b0000, s.sym[1:0]};
                        take_count({sv[3:0], s.sym[5:2]}, 3'd3);
                    end
                    default:
                        take_count({sv[1:0], s.sym}, 3'd0);
                endcase
            end
        endcase
    endtask

    task automatic compare_result(input decoded_t got);
        decoded_t want;
        if (pending_results.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: result with nothing expected: %s%0d byte=%02h rep=%0d crc=%04h",
                         $realtime, "kind=", got.kind, got.value, got.copies, got.check);
            return;
        end
        want = pending_results.pop_front();
        case (want.kind)
            bhx_pkg::KIND_DATA:
            begin
                data_runs++;
                if (want.copies >= 100)
                    long_runs++;
            end
            bhx_pkg::KIND_END: end_marks++;
            default:           bad_chars++;
        endcase
        if (got.kind !== want.kind || got.value !== want.value ||
            got.copies !== want.copies || got.check !== want.check)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("%0t: mismatch: expected kind=%0d byte=%02h rep=%0d crc=%04h,",
                         $realtime, want.kind, want.value, want.copies, want.check);
                $display("    got kind=%0d byte=%02h rep=%0d crc=%04h",
                         got.kind, got.value, got.copies, got.check);
            end
        end
    endtask

    // A result can never come out at the edge that accepts its character,
    // so the output side is checked before the input side is predicted.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            pending_results.delete();
            dec_phase   = '0;
            carry_bits  = '0;
            crc_acc     = '0;
            prev_value  = '0;
            mismatches  = 0;
            data_runs   = 0;
            long_runs   = 0;
            end_marks   = 0;
            bad_chars   = 0;
            outstanding = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                compare_result({m_tuser, m_tdata[7:0], m_tdata[15:8], m_tdata[31:16]});
            if (s_tvalid && s_tready)
                advance_decoder(s_tuser, s_tdata);
            outstanding = pending_results.size();
        end
    end

endmodule

### tb/sv/tb_six_bit_rle_crc_decoder.sv
`timescale 1ns / 1ps

module tb_six_bit_rle_crc_decoder;

    localparam logic [7:0] CR    = 8'h0D;
    localparam logic [7:0] LF    = 8'h0A;
    localparam logic [7:0] COLON = 8'h3A;
    localparam int CHAR_TARGET   = 1900;
    localparam int HOLD_CYCLES   = 400;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // char_code[7:0]
    logic        s_tuser;    // mode
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;    // data_byte[7:0], repeat_res[15:8], check_value[31:16]
    logic [1:0]  m_tuser;    // kind

    int         mismatches;
    int         outstanding;
    int         data_runs;
    int         long_runs;
    int         end_marks;
    int         bad_chars;
    logic [1:0] symbol_slot;

    int   chars_fed = 0;
    logic quiet     = 1'b0;
    logic hold_req  = 1'b0;

    six_bit_rle_crc_decoder uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    bhx_result_checker result_chk
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .data_runs   (data_runs),
        .long_runs   (long_runs),
        .end_marks   (end_marks),
        .bad_chars   (bad_chars),
        .symbol_slot (symbol_slot)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Receiver: random stalls, plus one long hold-off on request.
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
                m_tready <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 99) < 12)
                m_tready <= 1'b0;
            else
                m_tready <= 1'b1;
        end
    end

    function automatic logic [7:0] symbol_char(input logic [5:0] s);
        if (s < 13) return 8'h21 + 8'(s);
        if (s < 20) return 8'h30 + 8'(s - 13);
        if (s < 22) return 8'h38 + 8'(s - 20);
        if (s < 37) return 8'h40 + 8'(s - 22);
        if (s < 44) return 8'h50 + 8'(s - 37);
        if (s < 48) return 8'h58 + 8'(s - 44);
        if (s < 55) return 8'h60 + 8'(s - 48);
        if (s < 61) return 8'h68 + 8'(s - 55);
        return 8'h70 + 8'(s - 61);
    endfunction

    function automatic logic [7:0] illegal_char();
        case ($urandom_range(0, 5))
            0:       return 8'($urandom_range(8'h00, 8'h09));
            1:       return 8'($urandom_range(8'h0E, 8'h20));
            2:       return 8'h37;
            3:       return 8'h4F;
            4:       return 8'($urandom_range(8'h5C, 8'h5F));
            default: return 8'($urandom_range(8'h73, 8'hFF));
        endcase
    endfunction

    // Mostly short runs; a few reach the longest count.
    function automatic logic [7:0] run_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20) return 8'd0;
        if (r < 35) return 8'd1;
        if (r < 75) return 8'($urandom_range(2, 8));
        if (r < 96) return 8'($urandom_range(9, 64));
        return 8'($urandom_range(65, 255));
    endfunction

    task automatic put_char(input logic clr, input logic [7:0] code);
        while (!quiet && $urandom_range(0, 99) < 12)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= clr;
        s_tdata  <= code;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        @(negedge clk);
        if (clr || (code != CR && code != LF))
            chars_fed++;
    endtask

    task automatic send_group(input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] b2);
        logic [23:0] bits;
        bits = {b0, b1, b2};
        for (int i = 3; i >= 0; i--)
            put_char(1'b0, symbol_char(bits[i*6 +: 6]));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0) @(negedge clk);
    endtask

    // Encoded text: realign to a group boundary, then whole groups of bytes
    // with runs, stray line breaks or illegal characters; usually an end marker.
    task automatic send_frame();
        logic [7:0] stream[$];
        int         groups;
        int         r;
        while (symbol_slot != 2'd0)
            put_char(1'b0, symbol_char(6'($urandom_range(0, 63))));
        if ($urandom_range(0, 99) < 15)
            put_char(1'b1, 8'($urandom_range(0, 255)));
        groups = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 5);
        while (stream.size() < groups * 3)
        begin
            r = $urandom_range(0, 99);
            if (r < 12)
            begin
                stream.push_back(bhx_pkg::RUN_MARK);
                stream.push_back(run_count());
            end
            else if (r < 20 && stream.size() > 0)
                stream.push_back(stream[$]);
            else
                stream.push_back(8'($urandom_range(0, 255)));
        end
        while (stream.size() % 3 != 0)
            stream.push_back(8'($urandom_range(0, 255)));
        for (int k = 0; k < stream.size(); k += 3)
        begin
            if ($urandom_range(0, 99) < 6)
                put_char(1'b0, $urandom_range(0, 1) ? CR : LF);
            if ($urandom_range(0, 99) < 3)
                put_char(1'b0, illegal_char());
            send_group(stream[k], stream[k+1], stream[k+2]);
        end
        if ($urandom_range(0, 99) < 60)
            put_char(1'b0, COLON);
    endtask

    // Arbitrary characters, clears, or a group cut short.
    task automatic send_noise();
        int n;
        n = $urandom_range(1, 8);
        if ($urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 3))
                put_char(1'b0, symbol_char(6'($urandom_range(0, 63))));
        else
            repeat (n) put_char($urandom_range(0, 9) == 0, 8'($urandom_range(0, 255)));
    endtask

    initial
    begin
        int   leftover;
        logic held;
        logic drained;
        held     = 1'b0;
        drained  = 1'b0;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 8'h00;
        s_tuser  = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: a run before any data repeats zero, a zero count, a count
        // of one, the longest run, then end marker, line breaks, illegal
        // characters at both ends of the code range, and a clear.
        send_group(bhx_pkg::RUN_MARK, 8'h03, 8'hFF);
        send_group(bhx_pkg::RUN_MARK, 8'h00, 8'h00);
        send_group(bhx_pkg::RUN_MARK, 8'h01, 8'h00);
        send_group(8'hAB, bhx_pkg::RUN_MARK, 8'hFF);
        put_char(1'b0, COLON);
        put_char(1'b0, CR);
        put_char(1'b0, LF);
        put_char(1'b0, 8'h00);
        put_char(1'b0, 8'hFF);
        put_char(1'b1, 8'hFF);
        send_group(8'h12, 8'h34, 8'h56);
        wait_drained();

        while (chars_fed < CHAR_TARGET)
        begin
            if (!held && chars_fed >= 400)
            begin
                hold_req = 1'b1;
                held     = 1'b1;
            end
            quiet = (chars_fed >= 700 && chars_fed < 1000);
            if (!drained && chars_fed >= 1100)
            begin
                wait_drained();
                drained = 1'b1;
            end
            if ($urandom_range(0, 99) < 80)
                send_frame();
            else
                send_noise();
        end
        quiet = 1'b0;
        s_tvalid <= 1'b0;

        for (int k = 0; k < 200000 && outstanding != 0; k++)
            @(negedge clk);
        repeat (300) @(negedge clk);
        leftover = outstanding;
        if (leftover != 0)
            $display("%0d expected results never arrived", leftover);

        $display("Fed %0d characters; checked %0d data runs (%0d of 100 or more copies),",
                 chars_fed, data_runs, long_runs);
        $display("%0d end markers and %0d illegal characters, with clears and a long output stall.",
                 end_marks, bad_chars);
        if (mismatches == 0 && leftover == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
